/* rtl/multi_pin_shift_debouncer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pin debouncer checker
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_PIN_SHIFT_DEBOUNCER_MACROS_SVH
`define MULTI_PIN_SHIFT_DEBOUNCER_MACROS_SVH

// Implication checked on the same edge
`define MPSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the next edge
`define MPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mpsd_pkg.sv */
// ----------------------------------------------------------------------------
// mpsd_pkg
// Types and constants shared by the multi-pin shift-register debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsd_pkg;

    localparam int CHANNELS = 8;
    localparam int WINDOW   = 16;
    localparam int LANE_W   = $clog2(CHANNELS);

    // history patterns: oldest bit low then all high / oldest bit high then all low
    localparam logic [WINDOW-1:0] ON_PAT  = {1'b0, {(WINDOW-1){1'b1}}};
    localparam logic [WINDOW-1:0] OFF_PAT = {1'b1, {(WINDOW-1){1'b0}}};

    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_TAKE_RISE   = 3'd1;
    localparam logic [2:0] KIND_TAKE_FALL   = 3'd2;
    localparam logic [2:0] KIND_TAKE_CHANGE = 3'd3;
    localparam logic [2:0] KIND_SEED        = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

    typedef struct packed {
        logic [2:0]          kind;
        logic [CHANNELS-1:0] pin_samples;
        logic [LANE_W-1:0]   lane;
    } in_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0] levels;
        logic [CHANNELS-1:0] rising_flags;
        logic [CHANNELS-1:0] falling_flags;
        logic                flag_taken;
        logic                change_pending;
    } out_item_t;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic load;
        logic value;
        logic rise;
        logic fall;
    } lane_upd_t;

endpackage

`default_nettype wire

/* rtl/mpsd_lane.sv */
// ----------------------------------------------------------------------------
// mpsd_lane
// One debounce lane: history shift register and edge pattern match.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_lane
    import mpsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick,
    input  logic      seed,
    input  logic      sample,
    output lane_upd_t upd
);

    logic [WINDOW-1:0] history_reg;
    logic [WINDOW-1:0] history_next;
    logic [WINDOW-1:0] shifted;
    logic              rise;
    logic              fall;

    assign shifted = {history_reg[WINDOW-2:0], sample};
    assign rise    = tick && (shifted == ON_PAT);
    assign fall    = tick && (shifted == OFF_PAT);

    always_comb
    begin
        history_next = history_reg;
        if (tick)
        begin
            history_next = shifted;
        end
        else if (seed)
        begin
            history_next = {WINDOW{sample}};
        end
    end

    always_comb
    begin
        upd.rise  = rise;
        upd.fall  = fall;
        upd.load  = seed || rise || fall;
        upd.value = seed ? sample : rise;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
        end
        else
        begin
            history_reg <= history_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mpsd_merge.sv */
// ----------------------------------------------------------------------------
// mpsd_merge
// Combines lane findings into level and sticky flag state, serves queries.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_merge
    import mpsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [2:0]                 kind,
    input  logic [LANE_W-1:0]          lane,
    input  lane_upd_t [CHANNELS-1:0]   upd,
    output out_item_t                  result
);

    logic [CHANNELS-1:0] level_reg;
    logic [CHANNELS-1:0] level_next;
    logic [CHANNELS-1:0] rise_reg;
    logic [CHANNELS-1:0] rise_next;
    logic [CHANNELS-1:0] fall_reg;
    logic [CHANNELS-1:0] fall_next;
    logic                change_reg;
    logic                change_next;
    logic                taken;
    logic                any_hit;

    always_comb
    begin
        any_hit = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            level_next[i] = upd[i].load ? upd[i].value : level_reg[i];
            rise_next[i]  = rise_reg[i] | upd[i].rise;
            fall_next[i]  = fall_reg[i] | upd[i].fall;
            any_hit       = any_hit | upd[i].rise | upd[i].fall;
        end
        change_next = change_reg | any_hit;
        taken       = 1'b0;

        if (accept)
        begin
            case (kind)
                KIND_TAKE_RISE:
                begin
                    taken           = rise_reg[lane];
                    rise_next[lane] = 1'b0;
                end
                KIND_TAKE_FALL:
                begin
                    taken           = fall_reg[lane];
                    fall_next[lane] = 1'b0;
                end
                KIND_TAKE_CHANGE:
                begin
                    taken       = change_reg;
                    change_next = 1'b0;
                end
                default:
                begin
                    taken = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        result.levels         = level_next;
        result.rising_flags   = rise_next;
        result.falling_flags  = fall_next;
        result.flag_taken     = taken;
        result.change_pending = change_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            change_reg <= 1'b0;
        end
        else
        begin
            level_reg  <= level_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            change_reg <= change_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/multi_pin_shift_debouncer.sv */
// A result is registered and appears in the output register in the cycle after its input.
// One transaction per cycle unless output stalls; all lanes shift and match in parallel.
// The output register frees up in the cycle it is taken, so input ready follows out_ready.
// Reset (rst_n low, asynchronous) clears histories, levels, flags and both config masks.
// ----------------------------------------------------------------------------
// multi_pin_shift_debouncer
// Eight-lane shift-register debouncer with sticky edge and change flags.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pin_shift_debouncer
    import mpsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHANNELS-1:0]  cfg_data
);

    logic [CHANNELS-1:0]       invert_reg;
    logic [CHANNELS-1:0]       invert_next;
    logic [CHANNELS-1:0]       enable_reg;
    logic [CHANNELS-1:0]       enable_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_item_t                 out_data_reg;
    out_item_t                 result;
    logic                      accept;
    logic                      do_tick;
    logic                      do_seed;
    logic [CHANNELS-1:0]       samples;
    lane_upd_t [CHANNELS-1:0]  upd;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign do_tick   = accept && (in_data.kind == KIND_TICK);
    assign do_seed   = accept && (in_data.kind == KIND_SEED);
    assign samples   = in_data.pin_samples ^ invert_reg;

    always_comb
    begin
        invert_next = invert_reg;
        enable_next = enable_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INVERT: invert_next = cfg_data;
                CFG_ENABLE: enable_next = cfg_data;
                default:    invert_next = invert_reg;
            endcase
        end
    end

    generate
        for (genvar i = 0; i < CHANNELS; i++)
        begin : g_lane
            mpsd_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .tick   (do_tick && enable_reg[i]),
                .seed   (do_seed && enable_reg[i]),
                .sample (samples[i]),
                .upd    (upd[i])
            );
        end
    endgenerate

    mpsd_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (in_data.kind),
        .lane   (in_data.lane),
        .upd    (upd),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg    <= '0;
            enable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            invert_reg    <= invert_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/mpsd_checker.sv */
// ----------------------------------------------------------------------------
// mpsd_checker
// Port-level checks for the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_pin_shift_debouncer_macros.svh"

module mpsd_checker
    import mpsd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    `MPSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
        "result dropped while stalled")
    `MPSD_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid,
        "no result after transaction")
    `MPSD_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
        "input taken while output stalled")
    `MPSD_ASSERT_NEXT(a_tick_no_taken,
        in_valid && in_ready && (in_data.kind == KIND_TICK),
        !out_data.flag_taken, "flag_taken set on tick")
    `MPSD_ASSERT_NEXT(a_change_cleared,
        in_valid && in_ready && (in_data.kind == KIND_TAKE_CHANGE),
        !out_data.change_pending, "change flag not cleared")

endmodule

bind multi_pin_shift_debouncer mpsd_checker u_mpsd_checker (.*);

`default_nettype wire

/* tb/tb_multi_pin_shift_debouncer.sv */
// ----------------------------------------------------------------------------
// tb_multi_pin_shift_debouncer
// Self-checking bench for the eight-lane debouncer. A scoreboard carries a
// cycle-free model of the lane histories, levels and sticky flags, predicts
// one result per input transaction and compares it field by field with the
// output stream. Mask settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
import mpsd_pkg::*;

class debounce_scoreboard;

    localparam logic [WINDOW-1:0] RISE_HIST = {1'b0, {(WINDOW-1){1'b1}}};
    localparam logic [WINDOW-1:0] FALL_HIST = {1'b1, {(WINDOW-1){1'b0}}};

    logic [WINDOW-1:0]   hist [CHANNELS];
    logic [CHANNELS-1:0] lvl;
    logic [CHANNELS-1:0] rise_flags;
    logic [CHANNELS-1:0] fall_flags;
    logic                changed;
    logic [CHANNELS-1:0] invert_bits;
    logic [CHANNELS-1:0] enable_bits;
    out_item_t           pending_outputs [$];
    int                  failures;

    function new();
        int i;
        for (i = 0; i < CHANNELS; i++)
            hist[i] = '0;
        lvl         = '0;
        rise_flags  = '0;
        fall_flags  = '0;
        changed     = 1'b0;
        invert_bits = '0;
        enable_bits = '0;
        failures    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CHANNELS-1:0] value);
        if (idx == CFG_INVERT)
            invert_bits = value;
        else if (idx == CFG_ENABLE)
            enable_bits = value;
    endfunction

    // apply one transaction to the lane state and return the result it produces
    function out_item_t debounce_step(in_item_t it);
        logic [CHANNELS-1:0] smp;
        logic                got;
        out_item_t           res;
        int                  i;
        smp = it.pin_samples ^ invert_bits;
        got = 1'b0;
        case (it.kind)
            KIND_TICK, KIND_SEED:
            begin
                for (i = 0; i < CHANNELS; i++)
                begin
                    if (enable_bits[i])
                    begin
                        if (it.kind == KIND_SEED)
                        begin
                            hist[i] = {WINDOW{smp[i]}};
                            lvl[i]  = smp[i];
                        end
                        else
                        begin
                            hist[i] = {hist[i][WINDOW-2:0], smp[i]};
                            if (hist[i] == RISE_HIST)
                            begin
                                lvl[i]        = 1'b1;
                                rise_flags[i] = 1'b1;
                                changed       = 1'b1;
                            end
                            else if (hist[i] == FALL_HIST)
                            begin
                                lvl[i]        = 1'b0;
                                fall_flags[i] = 1'b1;
                                changed       = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_TAKE_RISE:
            begin
                got = rise_flags[it.lane];
                rise_flags[it.lane] = 1'b0;
            end
            KIND_TAKE_FALL:
            begin
                got = fall_flags[it.lane];
                fall_flags[it.lane] = 1'b0;
            end
            KIND_TAKE_CHANGE:
            begin
                got     = changed;
                changed = 1'b0;
            end
            default: ;
        endcase
        res.levels         = lvl;
        res.rising_flags   = rise_flags;
        res.falling_flags  = fall_flags;
        res.flag_taken     = got;
        res.change_pending = changed;
        return res;
    endfunction

    function void note_input(in_item_t it);
        pending_outputs.push_back(debounce_step(it));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("MISMATCH %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (pending_outputs.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("MISMATCH result with nothing pending: %p", got);
            return;
        end
        want = pending_outputs.pop_front();
        if (got.levels !== want.levels)
            report("levels", 32'(want.levels), 32'(got.levels));
        if (got.rising_flags !== want.rising_flags)
            report("rising_flags", 32'(want.rising_flags), 32'(got.rising_flags));
        if (got.falling_flags !== want.falling_flags)
            report("falling_flags", 32'(want.falling_flags), 32'(got.falling_flags));
        if (got.flag_taken !== want.flag_taken)
            report("flag_taken", 32'(want.flag_taken), 32'(got.flag_taken));
        if (got.change_pending !== want.change_pending)
            report("change_pending", 32'(want.change_pending), 32'(got.change_pending));
    endfunction

endclass

module tb_multi_pin_shift_debouncer;

    localparam logic [2:0]           KIND_RSVD_LO = 3'd5;
    localparam logic [2:0]           KIND_RSVD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam int                   PHASES       = 6;
    localparam int                   PHASE_ITEMS  = 230;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHANNELS-1:0]  cfg_data;

    debounce_scoreboard   tracker;
    logic [CHANNELS-1:0]  pin_state;
    bit                   quiet;
    int                   hold_left;

    multi_pin_shift_debouncer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic in_item_t make_item(logic [2:0] kind, logic [CHANNELS-1:0] smp,
                                           logic [LANE_W-1:0] lane);
        in_item_t it;
        it.kind        = kind;
        it.pin_samples = smp;
        it.lane        = lane;
        return it;
    endfunction

    // Mostly slowly wandering pins so histories settle and edges fire,
    // with queries, seeds, glitches and noise mixed in.
    function automatic in_item_t next_item();
        in_item_t it;
        int       pick;
        int       i;
        pick           = $urandom_range(0, 99);
        it.kind        = KIND_TICK;
        it.pin_samples = CHANNELS'($urandom_range(0, 255));
        it.lane        = LANE_W'($urandom_range(0, CHANNELS - 1));
        if (pick < 64)
        begin
            for (i = 0; i < CHANNELS; i++)
                if ($urandom_range(0, 19) == 0)
                    pin_state[i] = ~pin_state[i];
            it.pin_samples = pin_state;
            if ($urandom_range(0, 99) < 4)
                it.pin_samples[LANE_W'($urandom_range(0, CHANNELS - 1))] ^= 1'b1;
        end
        else if (pick < 74)
            it.kind = KIND_TAKE_RISE;
        else if (pick < 84)
            it.kind = KIND_TAKE_FALL;
        else if (pick < 89)
            it.kind = KIND_TAKE_CHANGE;
        else if (pick < 92)
        begin
            it.kind = KIND_SEED;
            if ($urandom_range(0, 1) == 0)
                it.pin_samples = pin_state;
        end
        else if (pick >= 96)
            it.kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input in_item_t it);
        logic took;
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
            took = in_ready;
            if (took)
                tracker.note_input(it);
            @(negedge clk);
        end while (!took);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHANNELS-1:0] value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
            took = cfg_ready;
            if (took)
                tracker.set_register(idx, value);
            @(negedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // result side: sampled at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);

    // receiver readiness, with an occasional long hold-off requested via hold_left
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int                  ph;
        logic [CHANNELS-1:0] inv_val;
        logic [CHANNELS-1:0] en_val;
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_INVERT;
        cfg_data  = '0;
        pin_state = '0;
        quiet     = 1'b0;
        hold_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: seed low, hold all pins high until every lane rises, then queries
        write_reg(CFG_INVERT, 8'h00);
        write_reg(CFG_ENABLE, 8'hFF);
        send_item(make_item(KIND_SEED, 8'h00, 3'd0));
        repeat (15) send_item(make_item(KIND_TICK, 8'hFF, 3'd7));
        send_item(make_item(KIND_TAKE_RISE, 8'h00, 3'd0));
        send_item(make_item(KIND_TAKE_RISE, 8'hFF, 3'd7));
        send_item(make_item(KIND_TAKE_FALL, 8'h00, 3'd3));
        send_item(make_item(KIND_TAKE_CHANGE, 8'h00, 3'd0));
        send_item(make_item(KIND_TAKE_CHANGE, 8'h00, 3'd0));
        send_item(make_item(KIND_SEED, 8'hA5, 3'd0));
        send_item(make_item(KIND_RSVD_LO, 8'h00, 3'd0));
        send_item(make_item(KIND_RSVD_HI, 8'hFF, 3'd7));
        send_item(make_item(KIND_TICK, 8'h00, 3'd0));
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    inv_val = 8'h00;
                    en_val  = 8'hFF;
                end
                1:
                begin
                    inv_val = 8'hFF;
                    en_val  = 8'hFF;
                end
                3:
                begin
                    inv_val = CHANNELS'($urandom_range(0, 255));
                    en_val  = 8'h00;
                end
                4:
                begin
                    inv_val = 8'h00;
                    en_val  = CHANNELS'($urandom_range(0, 255));
                end
                5:
                begin
                    inv_val = CHANNELS'($urandom_range(0, 255));
                    en_val  = 8'hFF;
                end
                default:
                begin
                    inv_val = CHANNELS'($urandom_range(0, 255));
                    en_val  = CHANNELS'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_INVERT, inv_val);
            write_reg(CFG_ENABLE, en_val);
            if (ph == 4)
                write_reg(CFG_SPARE, CHANNELS'($urandom_range(0, 255)));
            quiet     = (ph == 1);
            pin_state = CHANNELS'($urandom_range(0, 255));
            // long output stall while input keeps coming: block must back-pressure
            if (ph == 2)
                hold_left = 80;
            repeat (PHASE_ITEMS) send_item(next_item());
            drain();
        end

        if (tracker.pending_outputs.size() != 0)
            tracker.failures += tracker.pending_outputs.size();
        if (tracker.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
